### rtl/core/stream_buffer_sync_sequencer_assert.svh
// ----------------------------------------------------------------------------
// stream buffer sync sequencer assertion macros
// concurrent property wrappers shared by the rtl that checks itself
// ----------------------------------------------------------------------------
`ifndef STREAM_BUFFER_SYNC_SEQUENCER_ASSERT_SVH
`define STREAM_BUFFER_SYNC_SEQUENCER_ASSERT_SVH

// same-cycle implication, off during reset
`define SBSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbss same-cycle check failed");

// next-cycle implication, off during reset
`define SBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbss next-cycle check failed");

`endif

### rtl/core/sbss_pkg.sv
// ----------------------------------------------------------------------------
// sbss_pkg
// types, codes and constants of the stream buffer sync sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbss_pkg;

    // default parameter values
    localparam int DEF_TAG_LINES      = 16;
    localparam int DEF_PAGE_SHIFT     = 13;
    localparam int DEF_TAG_ADDR_SHIFT = 13;
    localparam int DEF_VALID_BIT      = 19;

    // fixed limits
    localparam int TAG_IDX_W       = 4;
    localparam int MAX_PAGES_SMALL = 62;
    localparam int MAX_SCAN_LINES  = 62;

    // register reset values
    localparam logic        RESET_BUFFER_ENABLE      = 1'b1;
    localparam logic [5:0]  RESET_TAG_SCAN_THRESHOLD = 6'd36;
    localparam logic [31:0] RESET_TIMEOUT_TICKS      = 32'd1000;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BUFFER_ENABLE      = 2'd0,
        CFG_TAG_SCAN_THRESHOLD = 2'd1,
        CFG_TIMEOUT_TICKS      = 2'd2
    } cfg_idx_t;

    // request types
    typedef enum logic [1:0] {
        REQ_SYNC     = 2'd0,
        REQ_TAG_LOAD = 2'd1,
        REQ_DONE     = 2'd2,
        REQ_TICK     = 2'd3
    } req_type_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_FLUSH    = 3'd0,
        KIND_SYNC     = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_TIMEOUT  = 3'd3,
        KIND_NOMATCH  = 3'd4,
        KIND_DISABLED = 3'd5,
        KIND_BUSY     = 3'd6
    } kind_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAGES,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // input beat
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] base_addr;
        logic [15:0] page_count;
        logic [42:0] sync_flag_addr;
        logic [3:0]  tag_index;
        logic [63:0] tag_word;
    } req_t;

    // result beat
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] flush_addr;
        logic [42:0] sync_addr;
        logic        last;
    } rsp_t;

    // configuration register set
    typedef struct packed {
        logic        buffer_enable;
        logic [5:0]  tag_scan_threshold;
        logic [31:0] timeout_ticks;
    } cfg_t;

    // tag memory access request
    typedef struct packed {
        logic                 wr_en;
        logic [TAG_IDX_W-1:0] wr_idx;
        logic [63:0]          wr_word;
        logic                 rd_en;
        logic [TAG_IDX_W-1:0] rd_idx;
    } mem_req_t;

    // lines that can hold a tag and get scanned
    function automatic int scan_lines(input int tag_lines);
        int n;
        n = tag_lines;
        if (n > (1 << TAG_IDX_W))
            n = 1 << TAG_IDX_W;
        if (n > MAX_SCAN_LINES)
            n = MAX_SCAN_LINES;
        return n;
    endfunction

endpackage

### rtl/core/sbss_tag_mem.sv
// ----------------------------------------------------------------------------
// sbss_tag_mem
// tag mirror memory, one write and one registered read port, valid per line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbss_tag_mem #(
    parameter int TAG_LINES = sbss_pkg::DEF_TAG_LINES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sbss_pkg::mem_req_t mem_req,
    output logic [63:0]        rd_word
);

    localparam int MEM_LINES = sbss_pkg::scan_lines(TAG_LINES);
    localparam int MEM_IDX_W = (MEM_LINES > 1) ? $clog2(MEM_LINES) : 1;

    logic [63:0]          tags_reg [MEM_LINES];
    logic [MEM_LINES-1:0] line_valid_reg;
    logic [63:0]          rd_data_reg;
    logic                 rd_hit_reg;
    logic [MEM_IDX_W-1:0] wr_idx;
    logic [MEM_IDX_W-1:0] rd_idx;

    assign wr_idx = mem_req.wr_idx[MEM_IDX_W-1:0];
    assign rd_idx = mem_req.rd_idx[MEM_IDX_W-1:0];

    // storage array and registered read data
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            tags_reg[wr_idx] <= mem_req.wr_word;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= tags_reg[rd_idx];
        end
    end

    // line valid bits, cleared at reset so unwritten lines read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                line_valid_reg[wr_idx] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                rd_hit_reg <= line_valid_reg[rd_idx];
            end
        end
    end

    assign rd_word = rd_hit_reg ? rd_data_reg : '0;

endmodule

### rtl/core/sbss_seq.sv
// ----------------------------------------------------------------------------
// sbss_seq
// request decode, flush sequencing, tag scan, done wait and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbss_seq #(
    parameter int TAG_LINES      = sbss_pkg::DEF_TAG_LINES,
    parameter int PAGE_SHIFT     = sbss_pkg::DEF_PAGE_SHIFT,
    parameter int TAG_ADDR_SHIFT = sbss_pkg::DEF_TAG_ADDR_SHIFT,
    parameter int VALID_BIT      = sbss_pkg::DEF_VALID_BIT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sbss_pkg::cfg_t     cfg,
    input  logic               req_valid,
    output logic               req_stall,
    input  sbss_pkg::req_t     req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sbss_pkg::rsp_t     rsp,
    output sbss_pkg::mem_req_t mem_req,
    input  logic [63:0]        rd_word
);

    localparam int MEM_LINES = sbss_pkg::scan_lines(TAG_LINES);
    localparam int MEM_IDX_W = (MEM_LINES > 1) ? $clog2(MEM_LINES) : 1;
    localparam logic [MEM_IDX_W-1:0] LAST_IDX  = MEM_IDX_W'(MEM_LINES - 1);
    localparam logic [31:0]          PAGE_STEP = 32'(1) << PAGE_SHIFT;
    localparam logic [5:0]           THR_MAX   = 6'(sbss_pkg::MAX_PAGES_SMALL);

    sbss_pkg::state_t     state_reg, state_next;
    logic [31:0]          base_reg, base_next;
    logic [31:0]          hi_reg, hi_next;
    logic [42:0]          flag_reg, flag_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [MEM_IDX_W-1:0] idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic                 waiting_reg, waiting_next;
    logic [31:0]          wait_cnt_reg, wait_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    sbss_pkg::rsp_t       out_data_reg, out_data_next;

    logic                 out_free;
    logic                 accept;
    logic                 emit;
    sbss_pkg::rsp_t       beat;
    logic [15:0]          pages_eff;
    logic [5:0]           thr_eff;
    logic [63:0]          tag_shifted;
    logic [31:0]          tag_addr;
    logic                 tag_match;

    // one result beat
    function automatic sbss_pkg::rsp_t make_beat(input logic [2:0] kind,
                                                 input logic [31:0] fa,
                                                 input logic [42:0] sa,
                                                 input logic lst);
        sbss_pkg::rsp_t b;
        b.result_kind = kind;
        b.flush_addr  = fa;
        b.sync_addr   = sa;
        b.last        = lst;
        return b;
    endfunction

    // handshake
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != sbss_pkg::ST_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // request operands
    assign pages_eff = (req.page_count == 16'd0) ? 16'd1 : req.page_count;
    assign thr_eff   = (cfg.tag_scan_threshold > THR_MAX) ? THR_MAX : cfg.tag_scan_threshold;

    // scanned line address and range test
    assign tag_shifted = rd_word << TAG_ADDR_SHIFT;
    assign tag_addr    = tag_shifted[31:0];
    assign tag_match   = rd_word[VALID_BIT] && (tag_addr >= base_reg) && (tag_addr <= hi_reg);

    // next state and beat generation
    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        hi_next       = hi_reg;
        flag_next     = flag_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        waiting_next  = waiting_reg;
        wait_cnt_next = wait_cnt_reg;
        emit          = 1'b0;
        beat          = make_beat(sbss_pkg::KIND_FLUSH, '0, '0, 1'b0);
        mem_req       = '0;

        unique case (state_reg)
            sbss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        sbss_pkg::REQ_SYNC:
                        begin
                            priority if (!cfg.buffer_enable)
                            begin
                                emit = 1'b1;
                                beat = make_beat(sbss_pkg::KIND_DISABLED, '0, '0, 1'b1);
                            end
                            else if (waiting_reg)
                            begin
                                emit = 1'b1;
                                beat = make_beat(sbss_pkg::KIND_BUSY, '0, '0, 1'b1);
                            end
                            else
                            begin
                                base_next = req.base_addr;
                                flag_next = req.sync_flag_addr;
                                if (pages_eff > {10'd0, thr_eff})
                                begin
                                    // range too large: scan the tag mirror
                                    hi_next        = req.base_addr
                                                   + (32'(pages_eff) << PAGE_SHIFT);
                                    idx_next       = '0;
                                    found_next     = 1'b0;
                                    mem_req.rd_en  = 1'b1;
                                    mem_req.rd_idx = '0;
                                    state_next     = sbss_pkg::ST_SCAN;
                                end
                                else
                                begin
                                    cnt_next   = 6'(pages_eff - 16'd1);
                                    found_next = 1'b1;
                                    state_next = sbss_pkg::ST_PAGES;
                                end
                            end
                        end
                        sbss_pkg::REQ_TAG_LOAD:
                        begin
                            if (32'(req.tag_index) < 32'(MEM_LINES))
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_idx  = req.tag_index;
                                mem_req.wr_word = req.tag_word;
                            end
                        end
                        sbss_pkg::REQ_DONE:
                        begin
                            if (waiting_reg)
                            begin
                                emit          = 1'b1;
                                beat          = make_beat(sbss_pkg::KIND_DONE, '0, '0, 1'b1);
                                waiting_next  = 1'b0;
                                wait_cnt_next = '0;
                            end
                        end
                        sbss_pkg::REQ_TICK:
                        begin
                            if (waiting_reg)
                            begin
                                // count + 1 above limit is count at or above limit
                                if (wait_cnt_reg >= cfg.timeout_ticks)
                                begin
                                    emit          = 1'b1;
                                    beat          = make_beat(sbss_pkg::KIND_TIMEOUT,
                                                              '0, '0, 1'b1);
                                    waiting_next  = 1'b0;
                                    wait_cnt_next = '0;
                                end
                                else
                                begin
                                    wait_cnt_next = wait_cnt_reg + 32'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sbss_pkg::ST_PAGES:
            begin
                // one flush per page
                if (out_free)
                begin
                    emit      = 1'b1;
                    beat      = make_beat(sbss_pkg::KIND_FLUSH, base_reg, '0, 1'b0);
                    base_next = base_reg + PAGE_STEP;
                    if (cnt_reg == 6'd0)
                        state_next = sbss_pkg::ST_FINISH;
                    else
                        cnt_next = cnt_reg - 6'd1;
                end
            end
            sbss_pkg::ST_SCAN:
            begin
                // read data holds while a matching line waits for the output
                if (!(tag_match && !out_free))
                begin
                    if (tag_match)
                    begin
                        emit       = 1'b1;
                        beat       = make_beat(sbss_pkg::KIND_FLUSH, tag_addr, '0, 1'b0);
                        found_next = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = sbss_pkg::ST_FINISH;
                    end
                    else
                    begin
                        idx_next       = idx_reg + MEM_IDX_W'(1);
                        mem_req.rd_en  = 1'b1;
                        mem_req.rd_idx = sbss_pkg::TAG_IDX_W'(idx_next);
                    end
                end
            end
            sbss_pkg::ST_FINISH:
            begin
                // sync write after flushes, or no match
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = sbss_pkg::ST_IDLE;
                    if (found_reg)
                    begin
                        beat          = make_beat(sbss_pkg::KIND_SYNC, '0, flag_reg, 1'b1);
                        waiting_next  = 1'b1;
                        wait_cnt_next = '0;
                    end
                    else
                    begin
                        beat = make_beat(sbss_pkg::KIND_NOMATCH, '0, '0, 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = sbss_pkg::ST_IDLE;
            end
        endcase

        // output register
        out_valid_next = out_free ? emit : out_valid_reg;
        out_data_next  = (out_free && emit) ? beat : out_data_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbss_pkg::ST_IDLE;
            waiting_reg   <= 1'b0;
            wait_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            waiting_reg   <= waiting_next;
            wait_cnt_reg  <= wait_cnt_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        hi_reg       <= hi_next;
        flag_reg     <= flag_next;
        out_data_reg <= out_data_next;
    end

endmodule

### rtl/core/stream_buffer_sync_sequencer.sv
// ----------------------------------------------------------------------------
// stream_buffer_sync_sequencer
// flush and sync sequencer for a streaming write buffer, with tag mirror
// ----------------------------------------------------------------------------
// Takes one request beat at a time and puts each result in an output register.
// Tag loads, done events, ticks and rejected requests (disabled, busy) are
// handled as they are taken. A small range emits one flush beat per cycle
// while the output does not stall. A large range scans the tag mirror through
// its single registered read port, one line per cycle while no matching line
// waits for the output; the lines scanned are the smaller of TAG_LINES and 16.
// Line valid bits clear at reset, so no clearing pass is needed.
`timescale 1ns / 1ps

`include "stream_buffer_sync_sequencer_assert.svh"

module stream_buffer_sync_sequencer #(
    parameter int TAG_LINES      = sbss_pkg::DEF_TAG_LINES,
    parameter int PAGE_SHIFT     = sbss_pkg::DEF_PAGE_SHIFT,
    parameter int TAG_ADDR_SHIFT = sbss_pkg::DEF_TAG_ADDR_SHIFT,
    parameter int VALID_BIT      = sbss_pkg::DEF_VALID_BIT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_idx,
    input  logic [31:0]    cfg_data,
    input  logic           req_valid,
    output logic           req_stall,
    input  sbss_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sbss_pkg::rsp_t rsp
);

    sbss_pkg::cfg_t     cfg_reg;
    sbss_pkg::mem_req_t mem_req;
    logic [63:0]        rd_word;
    logic               req_take;
    logic               sync_off_take;
    logic               rsp_disabled;
    logic               rsp_flush;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_enable      <= sbss_pkg::RESET_BUFFER_ENABLE;
            cfg_reg.tag_scan_threshold <= sbss_pkg::RESET_TAG_SCAN_THRESHOLD;
            cfg_reg.timeout_ticks      <= sbss_pkg::RESET_TIMEOUT_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                sbss_pkg::CFG_BUFFER_ENABLE:
                    cfg_reg.buffer_enable <= cfg_data[0];
                sbss_pkg::CFG_TAG_SCAN_THRESHOLD:
                    cfg_reg.tag_scan_threshold <= cfg_data[5:0];
                sbss_pkg::CFG_TIMEOUT_TICKS:
                    cfg_reg.timeout_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    sbss_seq #(
        .TAG_LINES      (TAG_LINES),
        .PAGE_SHIFT     (PAGE_SHIFT),
        .TAG_ADDR_SHIFT (TAG_ADDR_SHIFT),
        .VALID_BIT      (VALID_BIT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .rd_word   (rd_word)
    );

    // tag mirror
    sbss_tag_mem #(
        .TAG_LINES (TAG_LINES)
    ) u_tag_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_word (rd_word)
    );

    // terms used by the checks below
    assign req_take      = req_valid && !req_stall;
    assign sync_off_take = req_take && (req.req_type == sbss_pkg::REQ_SYNC)
                           && !cfg_reg.buffer_enable;
    assign rsp_disabled  = rsp_valid && rsp.last
                           && (rsp.result_kind == sbss_pkg::KIND_DISABLED);
    assign rsp_flush     = (rsp.result_kind == sbss_pkg::KIND_FLUSH);

    // a request is taken only when its first beat has room
    `SBSS_ASSERT_SAME(a_accept_room, clk, rst_n, req_take, !(rsp_valid && rsp_stall))

    // a disabled buffer answers a sync request at once
    `SBSS_ASSERT_NEXT(a_disabled_reply, clk, rst_n, sync_off_take, rsp_disabled)

    // only flush beats are followed by more beats of the same request
    `SBSS_ASSERT_SAME(a_nonlast_flush, clk, rst_n, rsp_valid && !rsp.last, rsp_flush)

endmodule
